// ----- hw/rtl/key_typematic_repeat_unit_defines.svh -----
// Assertion macros shared by the typematic repeat checker.
`ifndef KEY_TYPEMATIC_REPEAT_UNIT_DEFINES_SVH
`define KEY_TYPEMATIC_REPEAT_UNIT_DEFINES_SVH

// Check the consequent on the clock after the antecedent.
`define KTR_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

// Check the consequent on the same clock as the antecedent.
`define KTR_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ktr_pkg.sv -----
// Types and constants of the typematic repeat unit.
`timescale 1ns / 1ps
package ktr_pkg;

   localparam int KEY_W   = 7;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int CSR_IW  = 1;

   localparam logic [CFG_W-1:0] START_RESET    = 16'd680;
   localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd48;

   // Result queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_DOWN = 2'd0,
      REQ_UP   = 2'd1,
      REQ_POLL = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_REPEAT_START,
      CSR_REPEAT_INTERVAL
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0] press_key;
      logic             is_repeat;
   } press_word_type;

   typedef struct packed {
      logic           push;
      press_word_type word;
   } push_type;

endpackage

// ----- hw/rtl/ktr_channels.sv -----
// Request and response channel interfaces of the typematic repeat unit.
`timescale 1ns / 1ps
interface ktr_req_if import ktr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [KEY_W-1:0]  key_index;
   logic [TIME_W-1:0] time_ms;

   modport source (output valid, output req_type, output key_index, output time_ms,
                   input ready);
   modport sink   (input valid, input req_type, input key_index, input time_ms,
                   output ready);
endinterface

interface ktr_rsp_if import ktr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] press_key;
   logic             is_repeat;

   modport source (output valid, output press_key, output is_repeat, input ready);
   modport sink   (input valid, input press_key, input is_repeat, output ready);
endinterface

// ----- hw/rtl/ktr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ktr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/ktr_out_fifo.sv -----
// Result queue that parts the engine from the response channel.
`timescale 1ns / 1ps
module ktr_out_fifo import ktr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic [OUT_CW-1:0] level,
   ktr_rsp_if.source         rsp_bus
);

   press_word_type    mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0] count_ff, count_in;
   logic              pop;

   assign pop = rsp_bus.valid & rsp_bus.ready;

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + OUT_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUT_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + OUT_CW'(push.push) - OUT_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wr_ptr_ff] <= push.word;
      end
   end

   assign rsp_bus.valid     = (count_ff != '0);
   assign rsp_bus.press_key = mem_ff[rd_ptr_ff].press_key;
   assign rsp_bus.is_repeat = mem_ff[rd_ptr_ff].is_repeat;
   assign level             = count_ff;

endmodule

// ----- hw/rtl/key_typematic_repeat_unit.sv -----
// Top level of the keyboard press and typematic repeat unit.
//
//   channel  dir  handshake     word
//   req_bus  in   valid/ready   req_type, key_index, time_ms
//   rsp_bus  out  valid/ready   press_key, is_repeat
//   csr_*    in   csr_we only   csr_index, csr_wdata
//
// The held bitmap is read at accept, and the engine decides and writes
// back in the next cycle, one item per cycle while req_bus.ready is high.
// Reset starts a clearing pass over the held bitmap, one entry a cycle;
// req_bus.ready stays low until it ends.
// Results wait in a four-word queue; req_bus.ready drops only once the
// queue plus the word in flight could fill it.
`timescale 1ns / 1ps
module key_typematic_repeat_unit import ktr_pkg::*; #(
   parameter int KEYS = 128
) (
   input  logic              clock,
   input  logic              reset,
   ktr_req_if.sink           req_bus,
   ktr_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(KEYS);

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] start_ff;
   logic [CFG_W-1:0] interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= START_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REPEAT_START:    start_ff    <= csr_wdata;
            CSR_REPEAT_INTERVAL: interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- clear pass
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(KEYS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------ accept
   logic [OUT_CW-1:0] q_level;
   logic [OUT_CW:0]   q_claim;
   logic              accept;
   logic              s2_valid_ff;

   // Count the queued words plus the one the engine may push this cycle.
   assign q_claim       = (OUT_CW + 1)'(q_level) + (OUT_CW + 1)'(s2_valid_ff);
   assign req_bus.ready = ~clearing_ff && (q_claim < (OUT_CW + 1)'(OUT_DEPTH));
   assign accept        = req_bus.valid & req_bus.ready;

   // Stage two: the item whose held bit arrives from the RAM this cycle.
   logic [1:0]        s2_type_ff;
   logic [KEY_W-1:0]  s2_key_ff;
   logic [TIME_W-1:0] s2_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_type_ff <= req_bus.req_type;
         s2_key_ff  <= req_bus.key_index;
         s2_time_ff <= req_bus.time_ms;
      end
   end

   // ------------------------------------------------------ held bitmap
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic          ram_rdata;
   logic          eng_we;
   logic          eng_wdata;

   assign ram_we    = clearing_ff | eng_we;
   assign ram_waddr = clearing_ff ? clr_addr_ff : AW'(s2_key_ff);
   assign ram_wdata = clearing_ff ? 1'b0 : eng_wdata;

   ktr_ram #(
      .WIDTH (1),
      .DEPTH (KEYS)
   ) u_held_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (AW'(req_bus.key_index)),
      .rdata (ram_rdata)
   );

   // The RAM read of stage two shared its edge with the previous write;
   // forward that write when the addresses match.
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic          fwd_data_ff;
   logic          held_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= ram_we;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= ram_waddr;
      fwd_data_ff <= ram_wdata;
   end

   assign held_now = (fwd_valid_ff && (fwd_addr_ff == AW'(s2_key_ff))) ?
                     fwd_data_ff : ram_rdata;

   // ------------------------------------------------------------ engine
   logic              tracked_valid_ff, tracked_valid_in;
   logic [KEY_W-1:0]  tracked_key_ff,   tracked_key_in;
   logic              repeating_ff,     repeating_in;
   logic              fire_now_ff,      fire_now_in;
   logic [TIME_W-1:0] mark_time_ff,     mark_time_in;
   logic [TIME_W-1:0] elapsed;
   logic              start_hit;
   logic              interval_hit;
   logic              key_ok;
   push_type          push;

   assign key_ok       = (int'(s2_key_ff) < KEYS);
   assign elapsed      = s2_time_ff - mark_time_ff;   // wraps mod 2^32
   assign start_hit    = (elapsed >= TIME_W'(start_ff));
   assign interval_hit = (elapsed >= TIME_W'(interval_ff));

   // A tracked key is always held: key down sets both, and release of the
   // tracked key drops tracking, so the poll needs no bitmap read.
   always_comb begin
      tracked_valid_in = tracked_valid_ff;
      tracked_key_in   = tracked_key_ff;
      repeating_in     = repeating_ff;
      fire_now_in      = fire_now_ff;
      mark_time_in     = mark_time_ff;
      eng_we           = 1'b0;
      eng_wdata        = 1'b0;
      push             = '0;
      if (s2_valid_ff) begin
         case (s2_type_ff)
            REQ_DOWN: begin
               if (key_ok && !held_now) begin
                  eng_we                   = 1'b1;
                  eng_wdata                = 1'b1;
                  repeating_in             = 1'b0;
                  fire_now_in              = 1'b0;
                  mark_time_in             = s2_time_ff;
                  tracked_key_in           = s2_key_ff;
                  tracked_valid_in         = 1'b1;
                  push.push                = 1'b1;
                  push.word.press_key      = s2_key_ff;
                  push.word.is_repeat      = 1'b0;
               end
            end
            REQ_UP: begin
               if (key_ok) begin
                  eng_we    = 1'b1;
                  eng_wdata = 1'b0;
                  if (tracked_valid_ff && (tracked_key_ff == s2_key_ff)) begin
                     repeating_in     = 1'b0;
                     tracked_valid_in = 1'b0;
                     tracked_key_in   = '0;
                  end
               end
            end
            REQ_POLL: begin
               if (!tracked_valid_ff) begin
                  repeating_in = 1'b0;
               end else begin
                  // Enter repeat and fire on this same tick.
                  if (!repeating_ff && start_hit) begin
                     repeating_in = 1'b1;
                     fire_now_in  = 1'b1;
                  end
                  if (repeating_in && (fire_now_in || interval_hit)) begin
                     mark_time_in        = s2_time_ff;
                     fire_now_in         = 1'b0;
                     push.push           = 1'b1;
                     push.word.press_key = tracked_key_ff;
                     push.word.is_repeat = 1'b1;
                  end
               end
            end
            default: ;   // unused request code: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_valid_ff <= 1'b0;
         tracked_key_ff   <= '0;
         repeating_ff     <= 1'b0;
         fire_now_ff      <= 1'b0;
         mark_time_ff     <= '0;
      end else begin
         tracked_valid_ff <= tracked_valid_in;
         tracked_key_ff   <= tracked_key_in;
         repeating_ff     <= repeating_in;
         fire_now_ff      <= fire_now_in;
         mark_time_ff     <= mark_time_in;
      end
   end

   // ---------------------------------------------------------- results
   ktr_out_fifo u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .level   (q_level),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- hw/rtl/ktr_checker.sv -----
// Port-level checks of the typematic repeat unit, bound to its top level.
`timescale 1ns / 1ps
`include "key_typematic_repeat_unit_defines.svh"
module ktr_checker import ktr_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [KEY_W-1:0] press_key,
   input logic             is_repeat
);

   `KTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(press_key) && $stable(is_repeat), "stalled response word changed")
   `KTR_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready, "request taken during clearing pass")
   `KTR_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response without a request two cycles before")

endmodule

bind key_typematic_repeat_unit ktr_checker u_ktr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .press_key (rsp_bus.press_key),
   .is_repeat (rsp_bus.is_repeat)
);
